// ----- sv/aie_pkg.sv -----
// ----------------------------------------------------------------------------
// aie_pkg: shared types and codes for the instruction execute block
// Opcodes, status codes, unit operation codes and the request/response
// structs between the sequencer and the iterative arithmetic unit.
// ----------------------------------------------------------------------------
package aie_pkg;

	localparam int unsigned WORD_W   = 32;
	localparam int unsigned OPC_W    = 5;
	localparam int unsigned STATUS_W = 3;
	localparam int unsigned REGNUM_W = 5;
	localparam int unsigned UOP_W    = 3;

	// opcodes
	localparam logic [OPC_W-1:0] OPC_ADD    = 5'd1;
	localparam logic [OPC_W-1:0] OPC_SUB    = 5'd2;
	localparam logic [OPC_W-1:0] OPC_MUL    = 5'd3;
	localparam logic [OPC_W-1:0] OPC_DIV    = 5'd4;
	localparam logic [OPC_W-1:0] OPC_AND    = 5'd5;
	localparam logic [OPC_W-1:0] OPC_OR     = 5'd6;
	localparam logic [OPC_W-1:0] OPC_XOR    = 5'd7;
	localparam logic [OPC_W-1:0] OPC_NOP_LO = 5'd8;
	localparam logic [OPC_W-1:0] OPC_NOP_HI = 5'd18;
	localparam logic [OPC_W-1:0] OPC_STOP   = 5'd19;

	// unit operation codes (low bits of the matching opcode)
	localparam logic [UOP_W-1:0] UOP_ADD = 3'd1;
	localparam logic [UOP_W-1:0] UOP_SUB = 3'd2;
	localparam logic [UOP_W-1:0] UOP_MUL = 3'd3;
	localparam logic [UOP_W-1:0] UOP_DIV = 3'd4;
	localparam logic [UOP_W-1:0] UOP_AND = 3'd5;
	localparam logic [UOP_W-1:0] UOP_OR  = 3'd6;
	localparam logic [UOP_W-1:0] UOP_XOR = 3'd7;

	// result status
	localparam logic [STATUS_W-1:0] ST_EXEC    = 3'd0;
	localparam logic [STATUS_W-1:0] ST_NOP     = 3'd1;
	localparam logic [STATUS_W-1:0] ST_STOP    = 3'd2;
	localparam logic [STATUS_W-1:0] ST_UNKNOWN = 3'd3;
	localparam logic [STATUS_W-1:0] ST_IGNORED = 3'd4;

	typedef struct packed {
		logic              start;
		logic [UOP_W-1:0]  op;
		logic [WORD_W-1:0] a;
		logic [WORD_W-1:0] b;
	} unit_req_t;

	typedef struct packed {
		logic              done;
		logic [WORD_W-1:0] result;
	} unit_rsp_t;

endpackage

// ----- sv/aie_regfile.sv -----
// ----------------------------------------------------------------------------
// aie_regfile: register file memory
// One write port, two registered read ports. Per-entry valid bits make
// every entry read as zero after reset until it is written.
// ----------------------------------------------------------------------------
module aie_regfile #(
	parameter int unsigned DEPTH = 32,
	parameter int unsigned IDX_W = 5
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      rd_en,
	input  logic [IDX_W-1:0]          rd_addr_a,
	input  logic [IDX_W-1:0]          rd_addr_b,
	output logic [aie_pkg::WORD_W-1:0] rd_data_a,
	output logic [aie_pkg::WORD_W-1:0] rd_data_b,
	input  logic                      wr_en,
	input  logic [IDX_W-1:0]          wr_addr,
	input  logic [aie_pkg::WORD_W-1:0] wr_data
);
	import aie_pkg::*;

	logic [WORD_W-1:0] mem [DEPTH];
	logic [DEPTH-1:0]  valid_q;
	logic [WORD_W-1:0] data_a_q, data_b_q;
	logic              vld_a_q, vld_b_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			vld_a_q <= 1'b0;
			vld_b_q <= 1'b0;
		end else begin
			if (wr_en) begin
				valid_q[wr_addr] <= 1'b1;
			end
			if (rd_en) begin
				vld_a_q <= valid_q[rd_addr_a];
				vld_b_q <= valid_q[rd_addr_b];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			data_a_q <= mem[rd_addr_a];
			data_b_q <= mem[rd_addr_b];
		end
	end

	assign rd_data_a = vld_a_q ? data_a_q : '0;
	assign rd_data_b = vld_b_q ? data_b_q : '0;

endmodule

// ----- sv/aie_unit.sv -----
// ----------------------------------------------------------------------------
// aie_unit: iterative arithmetic unit
// One 33-bit adder/subtractor shared by add, sub, shift-add multiply
// (32 steps), restoring divide (32 steps plus sign fix) and negation.
// ----------------------------------------------------------------------------
module aie_unit (
	input  logic               clk,
	input  logic               arst_n,
	input  aie_pkg::unit_req_t req,
	output aie_pkg::unit_rsp_t rsp
);
	import aie_pkg::*;

	localparam logic [1:0] P_IDLE = 2'd0;
	localparam logic [1:0] P_MUL  = 2'd1;
	localparam logic [1:0] P_DIV  = 2'd2;
	localparam logic [1:0] P_FIX  = 2'd3;

	localparam int unsigned CNT_W = $clog2(WORD_W);

	logic [1:0]        phase_q;
	logic [CNT_W-1:0]  cnt_q;
	logic              done_q;
	logic [WORD_W-1:0] acc_q, x_q, y_q, result_q;
	logic              neg_q;

	logic [WORD_W-1:0] add_x, add_y;
	logic              add_sub;
	logic [WORD_W:0]   add_out;
	logic [WORD_W-1:0] div_shift;
	logic [16:0]       b_mag;

	assign div_shift = {acc_q[WORD_W-2:0], x_q[WORD_W-1]};
	// divisor is a sign-extended 16-bit value, so its magnitude fits 17 bits
	assign b_mag = req.b[WORD_W-1] ? (~req.b[16:0] + 17'd1) : req.b[16:0];

	always_comb begin
		add_x   = acc_q;
		add_y   = x_q;
		add_sub = 1'b0;
		unique case (phase_q)
			P_IDLE: begin
				if (req.op == UOP_DIV) begin
					add_x   = '0;
					add_y   = req.a;
					add_sub = 1'b1;
				end else begin
					add_x   = req.a;
					add_y   = req.b;
					add_sub = (req.op == UOP_SUB);
				end
			end
			P_MUL: begin
				add_x = acc_q;
				add_y = x_q;
			end
			P_DIV: begin
				add_x   = div_shift;
				add_y   = y_q;
				add_sub = 1'b1;
			end
			P_FIX: begin
				add_x   = '0;
				add_y   = x_q;
				add_sub = 1'b1;
			end
			default: ;
		endcase
	end

	assign add_out = {1'b0, add_x} + {1'b0, (add_sub ? ~add_y : add_y)}
		+ {{WORD_W{1'b0}}, add_sub};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= P_IDLE;
			cnt_q   <= '0;
			done_q  <= 1'b0;
		end else begin
			unique case (phase_q)
				P_IDLE: begin
					if (req.start) begin
						cnt_q <= '1;
						if (req.op == UOP_MUL) begin
							phase_q <= P_MUL;
							done_q  <= 1'b0;
						end else if (req.op == UOP_DIV && req.b != '0) begin
							phase_q <= P_DIV;
							done_q  <= 1'b0;
						end else begin
							done_q <= 1'b1;
						end
					end else begin
						done_q <= 1'b0;
					end
				end
				P_MUL: begin
					cnt_q  <= cnt_q - 1'b1;
					done_q <= (cnt_q == '0);
					if (cnt_q == '0) begin
						phase_q <= P_IDLE;
					end
				end
				P_DIV: begin
					cnt_q  <= cnt_q - 1'b1;
					done_q <= 1'b0;
					if (cnt_q == '0) begin
						phase_q <= P_FIX;
					end
				end
				P_FIX: begin
					phase_q <= P_IDLE;
					done_q  <= 1'b1;
				end
				default: begin
					phase_q <= P_IDLE;
					done_q  <= 1'b0;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (phase_q)
			P_IDLE: begin
				if (req.start) begin
					case (req.op) inside
						UOP_ADD, UOP_SUB: result_q <= add_out[WORD_W-1:0];
						UOP_AND: result_q <= req.a & req.b;
						UOP_OR:  result_q <= req.a | req.b;
						UOP_XOR: result_q <= req.a ^ req.b;
						UOP_MUL: begin
							acc_q <= '0;
							x_q   <= req.a;
							y_q   <= req.b;
						end
						UOP_DIV: begin
							result_q <= '1;
							acc_q    <= '0;
							x_q      <= req.a[WORD_W-1] ? add_out[WORD_W-1:0] : req.a;
							y_q      <= {{(WORD_W-17){1'b0}}, b_mag};
							neg_q    <= req.a[WORD_W-1] ^ req.b[WORD_W-1];
						end
						default: result_q <= '0;
					endcase
				end
			end
			P_MUL: begin
				if (y_q[0]) begin
					acc_q <= add_out[WORD_W-1:0];
				end
				x_q <= {x_q[WORD_W-2:0], 1'b0};
				y_q <= {1'b0, y_q[WORD_W-1:1]};
				result_q <= y_q[0] ? add_out[WORD_W-1:0] : acc_q;
			end
			P_DIV: begin
				// carry out means no borrow: take the trial remainder
				if (add_out[WORD_W]) begin
					acc_q <= add_out[WORD_W-1:0];
					x_q   <= {x_q[WORD_W-2:0], 1'b1};
				end else begin
					acc_q <= div_shift;
					x_q   <= {x_q[WORD_W-2:0], 1'b0};
				end
			end
			P_FIX: result_q <= neg_q ? add_out[WORD_W-1:0] : x_q;
			default: ;
		endcase
	end

	assign rsp.done   = done_q;
	assign rsp.result = result_q;

endmodule

// ----- sv/alu_instruction_execute.sv -----
// ----------------------------------------------------------------------------
// alu_instruction_execute: instruction decode and execute with register file
// Sequencer around a register file and an iterative arithmetic unit.
// ----------------------------------------------------------------------------
// Usage:
//   s_* channel takes one 32-bit instruction word per item. m_* channel
//   returns one result item per instruction: write enable, register
//   number, written value and a status code.
//   One item is worked on at a time; s_tready is high only while the
//   sequencer is idle. The register file is read on accept; the sequencer
//   then decodes in its read state. Add, sub, and, or, xor, mult and div
//   go on to the run state until the arithmetic unit is done; no-op,
//   stop, unknown and ignored items go straight to the done state, which
//   hands the result to the output register and returns to idle.
//   Mult and div run 32 steps through the shared adder of the
//   arithmetic unit, which sets the rate.
//   The result sits in an output register; the next instruction is
//   accepted while it waits. If the receiver stalls, a finished result is
//   held until the output register frees and the register write waits too.
//   Reset clears the register file (all zero), the halted flag and both
//   channels. Stop or an unknown opcode halts; later items are ignored.
// ----------------------------------------------------------------------------
module alu_instruction_execute #(
	parameter int unsigned REGISTER_COUNT = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,   // [31:0] instruction
	output logic        m_tvalid,
	input  logic        m_tready,
	// [0] write_enable, [5:1] write_index, [37:6] write_value, [40:38] status,
	// [47:41] zero
	output logic [47:0] m_tdata
);
	import aie_pkg::*;

	localparam int unsigned IDX_W  = $clog2(REGISTER_COUNT);
	localparam int unsigned NUM_IN = 2 ** REGNUM_W;

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_READ = 2'd1;
	localparam logic [1:0] S_RUN  = 2'd2;
	localparam logic [1:0] S_DONE = 2'd3;

	logic [1:0]          state_q;
	logic                halted_q;
	logic [WORD_W-1:0]   instr_q;
	logic                res_wr_q;
	logic [STATUS_W-1:0] res_status_q;
	logic [WORD_W-1:0]   res_value_q;
	logic                out_valid_q;
	logic [47:0]         out_data_q;

	logic [IDX_W-1:0]    sel_tbl [NUM_IN];
	logic [IDX_W-1:0]    src_idx, opr_idx, dst_idx;
	logic [OPC_W-1:0]    opc;
	logic [WORD_W-1:0]   imm;
	logic [WORD_W-1:0]   reg_a, reg_b;
	logic                accept, out_free, finish, is_alu;
	unit_req_t           ureq;
	unit_rsp_t           ursp;

	// register numbers reduced modulo the register count
	for (genvar i = 0; i < NUM_IN; i++) begin : g_sel
		assign sel_tbl[i] = IDX_W'(i % REGISTER_COUNT);
	end

	assign accept   = s_tvalid && s_tready;
	assign s_tready = (state_q == S_IDLE);
	assign out_free = !out_valid_q || m_tready;
	assign finish   = (state_q == S_DONE) && out_free;

	assign opc     = instr_q[31:27];
	assign imm     = {{16{instr_q[20]}}, instr_q[20:5]};
	assign dst_idx = sel_tbl[instr_q[4:0]];
	assign src_idx = sel_tbl[s_tdata[26:22]];
	assign opr_idx = sel_tbl[s_tdata[9:5]];
	assign is_alu  = (opc >= OPC_ADD) && (opc <= OPC_XOR);

	aie_regfile #(
		.DEPTH (REGISTER_COUNT),
		.IDX_W (IDX_W)
	) u_regfile (
		.clk       (clk),
		.arst_n    (arst_n),
		.rd_en     (accept),
		.rd_addr_a (src_idx),
		.rd_addr_b (opr_idx),
		.rd_data_a (reg_a),
		.rd_data_b (reg_b),
		.wr_en     (finish && res_wr_q),
		.wr_addr   (dst_idx),
		.wr_data   (res_value_q)
	);

	always_comb begin
		ureq.start = (state_q == S_READ) && !halted_q && is_alu;
		ureq.op    = opc[UOP_W-1:0];
		ureq.a     = reg_a;
		// add, sub and mult may take a register; the rest take the immediate
		if (!instr_q[21] && (opc == OPC_ADD || opc == OPC_SUB || opc == OPC_MUL)) begin
			ureq.b = reg_b;
		end else begin
			ureq.b = imm;
		end
	end

	aie_unit u_unit (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (ureq),
		.rsp    (ursp)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			halted_q    <= 1'b0;
			res_wr_q    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			// load on finish, drop once the receiver takes the item
			out_valid_q <= finish || (out_valid_q && !m_tready);
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						state_q <= S_READ;
					end
				end
				S_READ: begin
					res_wr_q <= !halted_q && is_alu;
					if (halted_q) begin
						state_q <= S_DONE;
					end else begin
						unique case (opc) inside
							[OPC_ADD:OPC_XOR]: state_q <= S_RUN;
							[OPC_NOP_LO:OPC_NOP_HI]: state_q <= S_DONE;
							default: begin
								halted_q <= 1'b1;
								state_q  <= S_DONE;
							end
						endcase
					end
				end
				S_RUN: begin
					if (ursp.done) begin
						state_q <= S_DONE;
					end
				end
				S_DONE: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			instr_q <= s_tdata;
		end
		if (state_q == S_READ) begin
			res_value_q <= '0;
			if (halted_q) begin
				res_status_q <= ST_IGNORED;
			end else begin
				unique case (opc) inside
					[OPC_ADD:OPC_XOR]:       res_status_q <= ST_EXEC;
					[OPC_NOP_LO:OPC_NOP_HI]: res_status_q <= ST_NOP;
					OPC_STOP:                res_status_q <= ST_STOP;
					default:                 res_status_q <= ST_UNKNOWN;
				endcase
			end
		end
		if (state_q == S_RUN && ursp.done) begin
			res_value_q <= ursp.result;
		end
		if (finish) begin
			out_data_q <= {7'd0, res_status_q, res_value_q,
				(res_wr_q ? REGNUM_W'(dst_idx) : {REGNUM_W{1'b0}}), res_wr_q};
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;

`ifndef SYNTHESIS
	a_done_in_run: assert property (@(posedge clk) disable iff (!arst_n)
		ursp.done |-> (state_q == S_RUN))
		else $error("arithmetic unit finished outside the run state");

	a_halt_sticks: assert property (@(posedge clk) disable iff (!arst_n)
		halted_q |=> halted_q)
		else $error("halted flag cleared without reset");

	a_nowrite_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tdata[0]) |-> (m_tdata[37:1] == '0))
		else $error("result without a write carries nonzero index or value");

	a_busy_not_ready: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_RUN) |-> !s_tready)
		else $error("input ready while an instruction is executing");
`endif

endmodule
